[rtl/rsc_pkg.sv]
// Shared widths, constants, queue and result types, and the back-end state
// encoding for the reset-subtract coadd block. No dependencies.
`default_nettype none

package rsc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COADD_W   = 32;
  localparam int MEAN_W    = 40;
  localparam int VAR_W     = 64;
  localparam int CNT_W     = 23;
  localparam int SUM_W     = 56;
  localparam int SQ_W      = 64;
  localparam int FRAC_BITS = 8;

  // frame length limit for statistics
  localparam logic [CNT_W-1:0] MAX_FRAME_PIXELS = 23'd4194304;

  localparam logic signed [COADD_W-1:0] COADD_MOST_NEG = 32'sh8000_0000;
  localparam logic signed [COADD_W-1:0] COADD_MOST_POS = 32'sh7FFF_FFFF;

  // front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // frame divider and mean square
  localparam int DVD_W    = SQ_W + FRAC_BITS;
  localparam int DIVCNT_W = 7;
  localparam int REM_W    = CNT_W + 1;
  localparam int MUL_W    = 32;
  localparam int HI_W     = MEAN_W - MUL_W;
  localparam int MSQ_W    = 2 * MEAN_W;

  typedef struct packed {
    logic signed [COADD_W-1:0] coadd;
    logic                      last;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic signed [COADD_W-1:0] coadd_out;
    logic                      stats_valid;
    logic signed [MEAN_W-1:0]  frame_mean;
    logic [VAR_W-1:0]          frame_variance;
    logic signed [COADD_W-1:0] frame_max;
    logic signed [COADD_W-1:0] frame_min;
  } res_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_ACCUM,
    BK_DIV_INIT,
    BK_DIV,
    BK_MSQ_LO,
    BK_MSQ_MID,
    BK_MSQ_HI,
    BK_MSQ_ADD,
    BK_FINAL,
    BK_EMIT
  } bk_state_t;

endpackage

`default_nettype wire

[rtl/rsc_chan_if.sv]
// Valid/ready channel interfaces for pixel words in and coadd result words out.
// Depends on rsc_pkg for field widths.
`default_nettype none

interface rsc_in_if;
  logic                               valid;
  logic                               ready;
  logic [rsc_pkg::SAMPLE_W-1:0]       exposed_sample;
  logic [rsc_pkg::SAMPLE_W-1:0]       reset_sample;
  logic signed [rsc_pkg::COADD_W-1:0] coadd_in;
  logic                               last_pixel;

  modport source (output valid, output exposed_sample, output reset_sample,
                  output coadd_in, output last_pixel, input ready);
  modport sink   (input valid, input exposed_sample, input reset_sample,
                  input coadd_in, input last_pixel, output ready);
endinterface

interface rsc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rsc_pkg::COADD_W-1:0] coadd_out;
  logic                               stats_valid;
  logic signed [rsc_pkg::MEAN_W-1:0]  frame_mean;
  logic [rsc_pkg::VAR_W-1:0]          frame_variance;
  logic signed [rsc_pkg::COADD_W-1:0] frame_max;
  logic signed [rsc_pkg::COADD_W-1:0] frame_min;

  modport source (output valid, output coadd_out, output stats_valid,
                  output frame_mean, output frame_variance, output frame_max,
                  output frame_min, input ready);
  modport sink   (input valid, input coadd_out, input stats_valid,
                  input frame_mean, input frame_variance, input frame_max,
                  input frame_min, output ready);
endinterface

`default_nettype wire

[rtl/rsc_front.sv]
// Front end: accepts pixel words, forms the updated coadd value and tags the
// frame end, pushing one queue entry per word. Depends on rsc_pkg, rsc_chan_if.
`default_nettype none

module rsc_front (
  rsc_in_if.sink            in_ch,
  input  logic              q_full,
  output rsc_pkg::q_push_t  q_push
);

  logic [rsc_pkg::COADD_W-1:0] coadd_sum;

  // wrap at 32 bits: coadd + exposed - reset
  assign coadd_sum = in_ch.coadd_in
                   + {{(rsc_pkg::COADD_W-rsc_pkg::SAMPLE_W){1'b0}}, in_ch.exposed_sample}
                   - {{(rsc_pkg::COADD_W-rsc_pkg::SAMPLE_W){1'b0}}, in_ch.reset_sample};

  assign in_ch.ready        = !q_full;
  assign q_push.push        = in_ch.valid && !q_full;
  assign q_push.entry.coadd = coadd_sum;
  assign q_push.entry.last  = in_ch.last_pixel;

endmodule

`default_nettype wire

[rtl/rsc_queue.sv]
// Short FIFO between the front end and the statistics back end.
// Depends on rsc_pkg.
`default_nettype none

module rsc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  rsc_pkg::q_push_t  q_push,
  output logic              q_full,
  output rsc_pkg::q_head_t  q_head,
  input  logic              q_pop
);

  rsc_pkg::q_entry_t           mem_r [rsc_pkg::QDEPTH];
  logic [rsc_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [rsc_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [rsc_pkg::QPTR_W:0]    fill_r, fill_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (q_push.push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    case ({q_push.push, q_pop})
      2'b10:   fill_nxt = fill_r + 1'b1;
      2'b01:   fill_nxt = fill_r - 1'b1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

  assign q_full       = (fill_r == (rsc_pkg::QPTR_W+1)'(rsc_pkg::QDEPTH));
  assign q_head.valid = (fill_r != '0);
  assign q_head.entry = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

[rtl/rsc_back.sv]
// Back end: squares and accumulates each coadd value, runs the frame-end
// divider and mean square, and holds the output register.
// Depends on rsc_pkg, rsc_chan_if.
`default_nettype none

module rsc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rsc_pkg::q_head_t  q_head,
  output logic              q_pop,
  rsc_out_if.source         out_ch
);

  rsc_pkg::bk_state_t                 state_r, state_nxt;
  logic [rsc_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic signed [rsc_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [rsc_pkg::SQ_W-1:0]           sumsq_r, sumsq_nxt;
  logic signed [rsc_pkg::COADD_W-1:0] max_r, max_nxt;
  logic signed [rsc_pkg::COADD_W-1:0] min_r, min_nxt;
  rsc_pkg::q_entry_t                  cur_r, cur_nxt;
  logic [2*rsc_pkg::MUL_W-1:0]        prod_r, prod_nxt;
  logic [rsc_pkg::DIVCNT_W-1:0]       div_cnt_r, div_cnt_nxt;
  logic [rsc_pkg::DVD_W-1:0]          dvd_e_r, dvd_e_nxt;
  logic [rsc_pkg::DVD_W-1:0]          dvd_m_r, dvd_m_nxt;
  logic [rsc_pkg::CNT_W-1:0]          rem_e_r, rem_e_nxt;
  logic [rsc_pkg::CNT_W-1:0]          rem_m_r, rem_m_nxt;
  logic                               sum_neg_r, sum_neg_nxt;
  logic [rsc_pkg::MSQ_W-1:0]          msq_r, msq_nxt;
  rsc_pkg::res_t                      res_r, res_nxt;
  rsc_pkg::res_t                      out_r, out_nxt;
  logic                               out_valid_r, out_valid_nxt;

  logic [rsc_pkg::MUL_W-1:0]          cur_mag;
  logic [rsc_pkg::MEAN_W-1:0]         mean_mag;
  logic signed [rsc_pkg::MEAN_W-1:0]  mean_val;
  logic [rsc_pkg::MUL_W-1:0]          mul_a, mul_b;
  logic [rsc_pkg::SQ_W:0]             sq_sum;
  logic [rsc_pkg::SUM_W-1:0]          sum_mag;
  logic [rsc_pkg::REM_W-1:0]          rem_e_sh, rem_m_sh, rem_e_sub, rem_m_sub;
  logic                               e_ge, m_ge;
  logic [rsc_pkg::DVD_W-1:0]          msq_sh;
  logic [rsc_pkg::DVD_W:0]            var_diff;
  logic [rsc_pkg::VAR_W-1:0]          var_val;

  assign cur_mag  = cur_r.coadd[rsc_pkg::COADD_W-1] ? (~cur_r.coadd + 1'b1) : cur_r.coadd;
  assign mean_mag = dvd_m_r[rsc_pkg::MEAN_W-1:0];
  assign mean_val = sum_neg_r ? (~mean_mag + 1'b1) : mean_mag;
  assign sum_mag  = sum_r[rsc_pkg::SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign sq_sum   = {1'b0, sumsq_r} + {1'b0, prod_r};

  // one quotient bit per cycle for both lanes, divisor is the pixel count
  assign rem_e_sh  = {rem_e_r, dvd_e_r[rsc_pkg::DVD_W-1]};
  assign rem_m_sh  = {rem_m_r, dvd_m_r[rsc_pkg::DVD_W-1]};
  assign rem_e_sub = rem_e_sh - {1'b0, count_r};
  assign rem_m_sub = rem_m_sh - {1'b0, count_r};
  assign e_ge      = (rem_e_sh >= {1'b0, count_r});
  assign m_ge      = (rem_m_sh >= {1'b0, count_r});

  // variance = E[x^2] - mean^2, clamp below zero, saturate above 64 bits
  assign msq_sh   = msq_r[rsc_pkg::MSQ_W-1:rsc_pkg::FRAC_BITS];
  assign var_diff = {1'b0, dvd_e_r} - {1'b0, msq_sh};
  always_comb begin
    if (var_diff[rsc_pkg::DVD_W]) begin
      var_val = '0;
    end else if (|var_diff[rsc_pkg::DVD_W-1:rsc_pkg::VAR_W]) begin
      var_val = '1;
    end else begin
      var_val = var_diff[rsc_pkg::VAR_W-1:0];
    end
  end

  // shared 32x32 multiplier, product always registered
  always_comb begin
    unique case (state_r)
      rsc_pkg::BK_SQUARE: begin
        mul_a = cur_mag;
        mul_b = cur_mag;
      end
      rsc_pkg::BK_MSQ_LO: begin
        mul_a = mean_mag[rsc_pkg::MUL_W-1:0];
        mul_b = mean_mag[rsc_pkg::MUL_W-1:0];
      end
      rsc_pkg::BK_MSQ_MID: begin
        mul_a = rsc_pkg::MUL_W'(mean_mag[rsc_pkg::MEAN_W-1:rsc_pkg::MUL_W]);
        mul_b = mean_mag[rsc_pkg::MUL_W-1:0];
      end
      rsc_pkg::BK_MSQ_HI: begin
        mul_a = rsc_pkg::MUL_W'(mean_mag[rsc_pkg::MEAN_W-1:rsc_pkg::MUL_W]);
        mul_b = rsc_pkg::MUL_W'(mean_mag[rsc_pkg::MEAN_W-1:rsc_pkg::MUL_W]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    cur_nxt       = cur_r;
    div_cnt_nxt   = div_cnt_r;
    dvd_e_nxt     = dvd_e_r;
    dvd_m_nxt     = dvd_m_r;
    rem_e_nxt     = rem_e_r;
    rem_m_nxt     = rem_m_r;
    sum_neg_nxt   = sum_neg_r;
    msq_nxt       = msq_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    q_pop         = 1'b0;

    unique case (state_r)
      rsc_pkg::BK_IDLE: begin
        if (q_head.valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_head.entry;
          state_nxt = rsc_pkg::BK_SQUARE;
        end
      end
      rsc_pkg::BK_SQUARE: begin
        state_nxt = rsc_pkg::BK_ACCUM;
      end
      rsc_pkg::BK_ACCUM: begin
        // drop pixels past the frame limit from the statistics
        if (count_r < rsc_pkg::MAX_FRAME_PIXELS) begin
          count_nxt = count_r + 1'b1;
          sum_nxt   = sum_r + rsc_pkg::SUM_W'(cur_r.coadd);
          sumsq_nxt = sq_sum[rsc_pkg::SQ_W] ? '1 : sq_sum[rsc_pkg::SQ_W-1:0];
          if (cur_r.coadd > max_r) begin
            max_nxt = cur_r.coadd;
          end
          if (cur_r.coadd < min_r) begin
            min_nxt = cur_r.coadd;
          end
        end
        res_nxt           = '0;
        res_nxt.coadd_out = cur_r.coadd;
        state_nxt = cur_r.last ? rsc_pkg::BK_DIV_INIT : rsc_pkg::BK_EMIT;
      end
      rsc_pkg::BK_DIV_INIT: begin
        dvd_e_nxt   = {sumsq_r, {rsc_pkg::FRAC_BITS{1'b0}}};
        dvd_m_nxt   = {{(rsc_pkg::DVD_W-rsc_pkg::SUM_W-rsc_pkg::FRAC_BITS){1'b0}},
                       sum_mag, {rsc_pkg::FRAC_BITS{1'b0}}};
        rem_e_nxt   = '0;
        rem_m_nxt   = '0;
        div_cnt_nxt = '0;
        sum_neg_nxt = sum_r[rsc_pkg::SUM_W-1];
        state_nxt   = rsc_pkg::BK_DIV;
      end
      rsc_pkg::BK_DIV: begin
        rem_e_nxt = e_ge ? rem_e_sub[rsc_pkg::CNT_W-1:0] : rem_e_sh[rsc_pkg::CNT_W-1:0];
        rem_m_nxt = m_ge ? rem_m_sub[rsc_pkg::CNT_W-1:0] : rem_m_sh[rsc_pkg::CNT_W-1:0];
        dvd_e_nxt = {dvd_e_r[rsc_pkg::DVD_W-2:0], e_ge};
        dvd_m_nxt = {dvd_m_r[rsc_pkg::DVD_W-2:0], m_ge};
        if (div_cnt_r == rsc_pkg::DIVCNT_W'(rsc_pkg::DVD_W - 1)) begin
          state_nxt = rsc_pkg::BK_MSQ_LO;
        end else begin
          div_cnt_nxt = div_cnt_r + 1'b1;
        end
      end
      rsc_pkg::BK_MSQ_LO: begin
        state_nxt = rsc_pkg::BK_MSQ_MID;
      end
      rsc_pkg::BK_MSQ_MID: begin
        msq_nxt   = rsc_pkg::MSQ_W'(prod_r);
        state_nxt = rsc_pkg::BK_MSQ_HI;
      end
      rsc_pkg::BK_MSQ_HI: begin
        // cross term counts twice
        msq_nxt   = msq_r + (rsc_pkg::MSQ_W'(prod_r) << (rsc_pkg::MUL_W + 1));
        state_nxt = rsc_pkg::BK_MSQ_ADD;
      end
      rsc_pkg::BK_MSQ_ADD: begin
        msq_nxt   = msq_r + (rsc_pkg::MSQ_W'(prod_r) << (2 * rsc_pkg::MUL_W));
        state_nxt = rsc_pkg::BK_FINAL;
      end
      rsc_pkg::BK_FINAL: begin
        res_nxt.coadd_out   = cur_r.coadd;
        res_nxt.stats_valid = 1'b1;
        res_nxt.frame_max   = max_r;
        res_nxt.frame_min   = min_r;
        if (count_r == '0) begin
          res_nxt.frame_mean     = '0;
          res_nxt.frame_variance = '0;
        end else begin
          res_nxt.frame_mean     = mean_val;
          res_nxt.frame_variance = var_val;
        end
        count_nxt = '0;
        sum_nxt   = '0;
        sumsq_nxt = '0;
        max_nxt   = rsc_pkg::COADD_MOST_NEG;
        min_nxt   = rsc_pkg::COADD_MOST_POS;
        state_nxt = rsc_pkg::BK_EMIT;
      end
      rsc_pkg::BK_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          if (q_head.valid) begin
            q_pop     = 1'b1;
            cur_nxt   = q_head.entry;
            state_nxt = rsc_pkg::BK_SQUARE;
          end else begin
            state_nxt = rsc_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = rsc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsc_pkg::BK_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      max_r       <= rsc_pkg::COADD_MOST_NEG;
      min_r       <= rsc_pkg::COADD_MOST_POS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      sumsq_r     <= sumsq_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    prod_r    <= prod_nxt;
    div_cnt_r <= div_cnt_nxt;
    dvd_e_r   <= dvd_e_nxt;
    dvd_m_r   <= dvd_m_nxt;
    rem_e_r   <= rem_e_nxt;
    rem_m_r   <= rem_m_nxt;
    sum_neg_r <= sum_neg_nxt;
    msq_r     <= msq_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.coadd_out      = out_r.coadd_out;
  assign out_ch.stats_valid    = out_r.stats_valid;
  assign out_ch.frame_mean     = out_r.frame_mean;
  assign out_ch.frame_variance = out_r.frame_variance;
  assign out_ch.frame_max      = out_r.frame_max;
  assign out_ch.frame_min      = out_r.frame_min;

endmodule

`default_nettype wire

[rtl/reset_subtract_coadd_with_stats.sv]
// Pixel words are queued at acceptance, independent of the back end; the back end takes
// one word at a time from the queue and works it through its square, accumulate and emit
// steps, squaring on its shared 32x32 multiplier; a frame-end word also runs the divider
// and mean-square steps before emit, and emit waits while the output register is held.
// Reset: synchronous, active low; clears queue, output valid and all frame statistics.
`default_nettype none

module reset_subtract_coadd_with_stats (
  input  logic       clk,
  input  logic       rst_n,
  rsc_in_if.sink     in_ch,
  rsc_out_if.source  out_ch
);

  // Front end: form the updated coadd value and tag the frame end.
  // Accept input words whenever the queue has room, independent of the back end.
  rsc_pkg::q_push_t q_push;
  logic             q_full;
  rsc_pkg::q_head_t q_head;
  logic             q_pop;

  rsc_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push)
  );

  // Four-entry queue: hold words while the back end squares, accumulates
  // or runs the frame-end division.
  rsc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  // Back end: square each value, update count, sum, sum of squares, max and min.
  // On a frame end, divide sum and sum of squares by the count (both lanes in
  // one 72-step loop), square the mean over four multiplier steps, then form
  // the clamped, saturated variance and clear the statistics. The output
  // register lets a finished word wait while the next one is worked on.
  rsc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  // Every frame has at least one counted pixel, so max never falls below min.
  a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.stats_valid) |->
      ($signed(out_ch.frame_max) >= $signed(out_ch.frame_min)))
    else $error("frame max below frame min");

  // Non-frame-end words carry zero statistics.
  a_zero_stats: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.stats_valid) |->
      (out_ch.frame_mean == '0 && out_ch.frame_variance == '0 &&
       out_ch.frame_max == '0 && out_ch.frame_min == '0))
    else $error("statistics fields set on a plain pixel word");

  // Pop only from a non-empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

[tb/sv/reset_subtract_coadd_with_stats_tb.sv]
// Self-checking bench for reset_subtract_coadd_with_stats: pixel words stream in,
// and a scoreboard predicts each coadd and frame-statistics word and checks it.
// Depends on rsc_pkg, rsc_in_if / rsc_out_if and the block itself.
`default_nettype none

// Tracks the frame statistics the block should be building and keeps the
// result words still owed by the block, oldest first.
class coadd_frame_scoreboard;
  rsc_pkg::res_t             pending_words[$];
  int unsigned               pix_count;
  longint                    acc_sum;
  logic [63:0]               acc_sumsq;
  logic signed [31:0]        acc_max;
  logic signed [31:0]        acc_min;
  int                        errors;
  int                        words_checked;
  int                        frames_closed;

  function new();
    errors        = 0;
    words_checked = 0;
    frames_closed = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    pix_count = 0;
    acc_sum   = 0;
    acc_sumsq = '0;
    acc_max   = rsc_pkg::COADD_MOST_NEG;
    acc_min   = rsc_pkg::COADD_MOST_POS;
  endfunction

  // Predict the result word for one accepted pixel word and queue it.
  function void note_pixel(logic [15:0] es, logic [15:0] rs, logic [31:0] ci, logic lp);
    rsc_pkg::res_t      want;
    logic [31:0]        cout_u;
    logic signed [31:0] cout_s;
    longint             cval;
    longint             mean_l;
    longint             mean_mag;
    logic [63:0]        sq;
    logic [127:0]       e2;
    logic [127:0]       m2;
    logic [127:0]       diff;
    logic [63:0]        var_q;
    cout_u = ci + {16'd0, es} - {16'd0, rs};
    cout_s = cout_u;
    cval   = cout_s;
    sq     = 64'(cval * cval);
    if (pix_count < 32'(rsc_pkg::MAX_FRAME_PIXELS)) begin
      pix_count++;
      acc_sum += cval;
      acc_sumsq = (acc_sumsq > ~64'd0 - sq) ? ~64'd0 : acc_sumsq + sq;
      if (cout_s > acc_max) acc_max = cout_s;
      if (cout_s < acc_min) acc_min = cout_s;
    end
    want = '0;
    want.coadd_out = cout_s;
    if (lp) begin
      mean_l = 0;
      var_q  = '0;
      if (pix_count != 0) begin
        // signed division truncates toward zero, as the block does
        mean_l   = (acc_sum * 64'sd256) / longint'(pix_count);
        e2       = ({64'd0, acc_sumsq} << 8) / 128'(pix_count);
        mean_mag = (mean_l < 0) ? -mean_l : mean_l;
        m2       = (128'(mean_mag) * 128'(mean_mag)) >> 8;
        if (e2 >= m2) begin
          diff  = e2 - m2;
          var_q = (diff[127:64] != 0) ? ~64'd0 : diff[63:0];
        end
      end
      want.stats_valid    = 1'b1;
      want.frame_mean     = mean_l[39:0];
      want.frame_variance = var_q;
      want.frame_max      = acc_max;
      want.frame_min      = acc_min;
      clear_frame();
    end
    pending_words.push_back(want);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Check one accepted result word against the oldest prediction.
  function void check_word(rsc_pkg::res_t got);
    rsc_pkg::res_t want;
    if (pending_words.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word: expected none, actual coadd %h",
               $time, got.coadd_out);
      return;
    end
    want = pending_words.pop_front();
    words_checked++;
    if (want.stats_valid) frames_closed++;
    compare_field("coadd_out", want.coadd_out, got.coadd_out);
    compare_field("stats_valid", want.stats_valid, got.stats_valid);
    compare_field("frame_mean", want.frame_mean, got.frame_mean);
    compare_field("frame_variance", want.frame_variance, got.frame_variance);
    compare_field("frame_max", want.frame_max, got.frame_max);
    compare_field("frame_min", want.frame_min, got.frame_min);
  endfunction
endclass

module reset_subtract_coadd_with_stats_tb;

  // Random stimulus stops once this many words have gone in; the tail of the
  // run (from TAIL_START on) runs with no idling on either side.
  localparam int RANDOM_TARGET = 1750;
  localparam int TAIL_START    = 1500;

  logic clk;
  logic rst_n;
  bit   quiet_tail;
  bit   sender_calm;
  int   words_sent;

  coadd_frame_scoreboard sb;

  rsc_in_if  in_ch ();
  rsc_out_if out_ch ();

  reset_subtract_coadd_with_stats dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hard stop: far beyond the slowest legal run, with full stalls on both sides
  // and a frame end on every word.
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Offer one pixel word and hold it until the block takes it; note the
  // prediction at the accepting edge.
  task automatic send_pixel(input logic [15:0] es, input logic [15:0] rs,
                            input logic [31:0] ci, input logic lp);
    in_ch.valid          <= 1'b1;
    in_ch.exposed_sample <= es;
    in_ch.reset_sample   <= rs;
    in_ch.coadd_in       <= ci;
    in_ch.last_pixel     <= lp;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_pixel(es, rs, ci, lp);
    words_sent++;
  endtask

  // Drop valid for a random burst now and then; never in calm stretches or the tail.
  task automatic sender_gap();
    if (!quiet_tail && !sender_calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Hold off the sender until the block has returned every owed word.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  // Coadd values: mostly full range, some near zero, some at the extremes so
  // the wrap and the saturating square sum get exercised.
  function automatic logic [31:0] pick_coadd();
    case ($urandom_range(0, 9))
      0:       return (($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                      - 32'($urandom_range(0, 3));
      1, 2:    return 32'($signed($urandom_range(0, 4000)) - 2000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_frame(input int len);
    logic [15:0] es;
    logic [15:0] rs;
    logic [31:0] ci;
    for (int k = 0; k < len; k++) begin
      sender_gap();
      es = pick_sample();
      rs = pick_sample();
      ci = pick_coadd();
      send_pixel(es, rs, ci, k == len - 1);
    end
  endtask

  // Result side: check the word at every edge where the block presents one and ready is high.
  always @(posedge clk) begin
    rsc_pkg::res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.coadd_out      = out_ch.coadd_out;
      got.stats_valid    = out_ch.stats_valid;
      got.frame_mean     = out_ch.frame_mean;
      got.frame_variance = out_ch.frame_variance;
      got.frame_max      = out_ch.frame_max;
      got.frame_min      = out_ch.frame_min;
      sb.check_word(got);
    end
  end

  // Receiver: ready mostly high, with random stall bursts now and then;
  // no stalls at all in the tail.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    int len;
    sb          = new();
    quiet_tail  = 1'b0;
    sender_calm = 1'b0;
    words_sent  = 0;
    rst_n       = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.exposed_sample = '0;
    in_ch.reset_sample   = '0;
    in_ch.coadd_in       = '0;
    in_ch.last_pixel     = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: sample extremes, coadd wrap from max positive to min negative.
    send_pixel(16'hFFFF, 16'h0000, 32'h0000_0000, 1'b0);
    send_pixel(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    sender_gap();
    send_pixel(16'h0000, 16'h0000, 32'h7FFF_FFFF, 1'b0);
    send_pixel(16'h0001, 16'h0000, 32'h7FFF_FFFF, 1'b1);
    // single-pixel frame: variance is exactly zero
    send_pixel(16'd100, 16'd50, 32'hFFFF_FFF9, 1'b1);
    // five pixels at the most negative value: square sum saturates, and the
    // variance clamps at zero because the mean square exceeds it
    for (int k = 0; k < 5; k++)
      send_pixel(16'h1234, 16'h1234, 32'h8000_0000, k == 4);
    // alternating extremes: mean near zero, variance saturates at 64 bits
    for (int k = 0; k < 4; k++)
      send_pixel(16'h0000, 16'h0000, k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, k == 3);
    // small negative frame: mean truncates toward zero
    send_pixel(16'd0, 16'd1, 32'd0, 1'b0);
    send_pixel(16'd7, 16'd8, 32'd0, 1'b0);
    send_pixel(16'd5, 16'd5, 32'd0, 1'b1);
    drain_results();

    // Random frames: mostly short, now and then a long one. Hold off for a full
    // drain every few hundred words, but never in the tail.
    while (words_sent < RANDOM_TARGET) begin
      if (words_sent >= TAIL_START) quiet_tail = 1'b1;
      sender_calm = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                         : $urandom_range(1, 24);
      random_frame(len);
      if (!quiet_tail && $urandom_range(0, 39) == 0) drain_results();
    end

    in_ch.valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    // let a late frame-end word show up if the block emits one it should not
    repeat (120) @(posedge clk);

    $display("Streamed %0d pixel words, checked %0d result words, %0d of them frame ends.",
             words_sent, sb.words_checked, sb.frames_closed);
    $display("Covered sample extremes, coadd wrap, square-sum and variance saturation.");
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
